// File: hw/rtl/aesrp_pkg.sv
// aesrp_pkg: item types, S-box table, byte permutation and GF(2^8) helpers
// for the permuted AES round block; depends on nothing else
`timescale 1ns / 1ps

package aesrp_pkg;

	// number of bytes in the state and in the round key
	localparam int unsigned NumBytes = 16;

	// one input item
	typedef struct packed {
		logic [63:0] state_high;
		logic [63:0] state_low;
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic        is_last;
	} rnd_item_t;

	// one result item
	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} res_item_t;

	typedef logic [7:0] byte_t;
	typedef byte_t      block_t [NumBytes];

	// standard AES S-box
	localparam byte_t SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	// extra permutation: new byte k takes old byte PERM[k]
	localparam logic [3:0] PERM [NumBytes] = '{
		4'd0,  4'd4,  4'd8,  4'd12,
		4'd7,  4'd11, 4'd15, 4'd3,
		4'd10, 4'd14, 4'd2,  4'd6,
		4'd13, 4'd1,  4'd5,  4'd9
	};

	// reduction byte of the field polynomial
	localparam byte_t GfPoly = 8'h1b;

	// multiply by 2 in GF(2^8)
	function automatic byte_t gf_dbl(input byte_t v);
		gf_dbl = {v[6:0], 1'b0} ^ (v[7] ? GfPoly : 8'h00);
	endfunction

	// multiply by 3 in GF(2^8)
	function automatic byte_t gf_tpl(input byte_t v);
		gf_tpl = gf_dbl(v) ^ v;
	endfunction

endpackage

// File: hw/rtl/aes_round_permuted.sv
// aes_round_permuted: one round of a permuted AES variant, two-register pipeline
// uses aesrp_pkg for item types, the S-box table and GF(2^8) helpers
// throughput: one item per cycle; the round logic sits between the input register and the
// result register, and the input only stalls with both registers full and res_stall high
// reset: clears only the two stage valid flags, data registers are not reset
`timescale 1ns / 1ps

module aes_round_permuted
	import aesrp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rnd_valid,
	output logic      rnd_stall,
	input  rnd_item_t rnd_item,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res_item
);

	logic      valid_s1;
	rnd_item_t item_s1;
	logic      valid_s2;
	res_item_t res_s2;

	logic adv_s1;
	logic adv_s2;

	logic [127:0] state_w;
	logic [127:0] key_w;
	logic [127:0] out_w;
	block_t       sb_b;
	block_t       mix_b;
	block_t       sel_b;
	block_t       fin_b;

	// pipeline advance: a stage loads when it is empty or its content moves on
	assign adv_s2    = !valid_s2 || !res_stall;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign rnd_stall = !adv_s1;

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= rnd_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		if (adv_s1 && rnd_valid) begin
			item_s1 <= rnd_item;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= '{result_high: out_w[127:64], result_low: out_w[63:0]};
		end
	end

	assign state_w = {item_s1.state_high, item_s1.state_low};
	assign key_w   = {item_s1.key_high, item_s1.key_low};

	// s-box with shiftrows: row r rotated left by r
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				sb_b[4*r+c] = SBOX[state_w[127 - 8*(4*r + ((c + r) % 4)) -: 8]];
			end
		end
	end

	// mixcolumns, bypassed on the final round
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			mix_b[c]    = gf_dbl(sb_b[c]) ^ gf_tpl(sb_b[4+c]) ^ sb_b[8+c] ^ sb_b[12+c];
			mix_b[4+c]  = sb_b[c] ^ gf_dbl(sb_b[4+c]) ^ gf_tpl(sb_b[8+c]) ^ sb_b[12+c];
			mix_b[8+c]  = sb_b[c] ^ sb_b[4+c] ^ gf_dbl(sb_b[8+c]) ^ gf_tpl(sb_b[12+c]);
			mix_b[12+c] = gf_tpl(sb_b[c]) ^ sb_b[4+c] ^ sb_b[8+c] ^ gf_dbl(sb_b[12+c]);
		end
		for (int i = 0; i < NumBytes; i++) begin
			sel_b[i] = item_s1.is_last ? sb_b[i] : mix_b[i];
		end
	end

	// extra byte permutation and key addition
	always_comb begin
		for (int k = 0; k < NumBytes; k++) begin
			fin_b[k] = sel_b[PERM[k]] ^ key_w[127 - 8*k -: 8];
			out_w[127 - 8*k -: 8] = fin_b[k];
		end
	end

	assign res_valid = valid_s2;
	assign res_item  = res_s2;

	// an accepted item always reaches the input register
	a_accept_loads : assert property (@(posedge clk) disable iff (!arst_n)
		rnd_valid && !rnd_stall |=> valid_s1)
		else $error("accepted item not held in input register");

	// stalling the input side only happens with both stages full
	a_stall_full : assert property (@(posedge clk) disable iff (!arst_n)
		rnd_stall |-> (valid_s1 && valid_s2 && res_stall))
		else $error("input stalled with room in the pipeline");

	// an item in the input register moves to the result register when it may
	a_s1_moves : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (!valid_s2 || !res_stall) |=> res_valid)
		else $error("item lost between stages");

endmodule
